[hdl/spn16_pkg.sv]
package spn16_pkg;

    typedef logic [15:0] t_block;

    localparam int FULL_ROUNDS = 3;

    localparam logic [3:0] SBOX [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    localparam logic [3:0] SBOX_BACK [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    // Bit i of the input moves to bit PERM[i] of the output.
    localparam logic [3:0] PERM [16] = '{
        4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd10, 4'd3, 4'd11,
        4'd4, 4'd12, 4'd5, 4'd13, 4'd6, 4'd14, 4'd7, 4'd15
    };

    function automatic t_block sub_fwd(input t_block v);
        t_block r;
        r = '0;
        for (int j = 0; j < 4; j++) begin
            r[4*j +: 4] = SBOX[v[4*j +: 4]];
        end
        return r;
    endfunction

    function automatic t_block sub_inv(input t_block v);
        t_block r;
        r = '0;
        for (int j = 0; j < 4; j++) begin
            r[4*j +: 4] = SBOX_BACK[v[4*j +: 4]];
        end
        return r;
    endfunction

    function automatic t_block perm_fwd(input t_block v);
        t_block r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[PERM[i]] = v[i];
        end
        return r;
    endfunction

    // The inverse permutation takes each output bit i from input bit PERM[i].
    function automatic t_block perm_back(input t_block v);
        t_block r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[PERM[i]];
        end
        return r;
    endfunction

endpackage

[hdl/spn16_datapath.sv]
module spn16_datapath
    import spn16_pkg::*;
(
    input  logic   i_func,
    input  t_block i_block,
    input  t_block i_key,
    output t_block o_block
);

    t_block enc;
    t_block dec;

    always_comb begin
        enc = i_block;
        for (int r = 0; r < FULL_ROUNDS; r++) begin
            enc = perm_fwd(sub_fwd(enc ^ i_key));
        end
        enc = sub_fwd(enc ^ i_key);
    end

    always_comb begin
        dec = sub_inv(i_block) ^ i_key;
        for (int r = 0; r < FULL_ROUNDS; r++) begin
            dec = sub_inv(perm_back(dec)) ^ i_key;
        end
    end

    assign o_block = i_func ? dec : enc;

endmodule

[hdl/spn16_block_cipher_core.sv]
// Four-round 16-bit substitution-permutation cipher with a single key.
// Input channel: i_in_valid / o_in_stall carry an item made of i_func
// (0 encrypt, 1 decrypt) and i_block_in. Output channel: o_out_valid /
// i_out_stall carry o_block_out. An item moves on a rising edge where
// valid is high and stall is low.
// The key is written through i_cfg_wr_en / i_cfg_wr_data and must only be
// changed while no item is in flight.
// An accepted item is held in the input register while all four rounds
// are computed in one combinational pass; the result register loads the
// result when it is empty or the receiver does not stall. Throughput is
// one item per cycle, set by that single pass, while i_out_stall is low.
// When the receiver stalls, the result register holds its item and the
// input register may still take one more item; only when both are full
// does o_in_stall rise.
// Synchronous active-low reset empties both registers and clears the key
// to zero.
module spn16_block_cipher_core
    import spn16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [15:0] i_block_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_block_out
);

    t_block r_cipher_key;
    logic   r_in_valid;
    logic   r_func;
    t_block r_block;
    logic   r_out_valid;
    t_block r_block_out;
    t_block n_block_out;
    logic   out_advance;
    logic   in_advance;

    assign out_advance = !r_out_valid || !i_out_stall;
    assign in_advance  = !r_in_valid || out_advance;
    assign o_in_stall  = !in_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_wr_en) begin
            r_cipher_key <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_in_valid) begin
            r_func  <= i_func;
            r_block <= i_block_in;
        end
    end

    spn16_datapath u_datapath (
        .i_func  (r_func),
        .i_block (r_block),
        .i_key   (r_cipher_key),
        .o_block (n_block_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_block_out <= n_block_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_block_out = r_block_out;

    a_in_to_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("Accepted item did not reach the input register.");

    a_reg_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_advance) |=> o_out_valid)
        else $error("Input register item was not moved to the result register.");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("Input stalled while the result register is empty.");

endmodule

[tb/sv/tb_spn16_block_cipher_core.sv]
module tb_spn16_block_cipher_core
    import spn16_pkg::*;
();

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_cipher_op;

    localparam int ROUNDS_WITH_PERM = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int REPORT_LIMIT = 10;

    // Nibble n of each table holds entry n.
    localparam logic [63:0] SBOX_FWD = 64'h7095C6A38BF21D4E;
    localparam logic [63:0] SBOX_REV = 64'h502B69D7FAC1843E;
    localparam logic [63:0] PERM_DEST = 64'hF7E6D5C4B3A29180;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_func;
    logic [15:0] i_block_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_block_out;

    t_block      cur_key;
    t_block      expected_blocks[$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_left;

    spn16_block_cipher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_block_in    (i_block_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_block_out   (o_block_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_block substitute(input t_block v, input logic reverse);
        t_block r;
        for (int n = 0; n < 4; n++) begin
            if (reverse) begin
                r[4*n +: 4] = SBOX_REV[4*v[4*n +: 4] +: 4];
            end else begin
                r[4*n +: 4] = SBOX_FWD[4*v[4*n +: 4] +: 4];
            end
        end
        return r;
    endfunction

    function automatic t_block predict_block(input t_cipher_op op, input t_block blk,
                                             input t_block key);
        t_block s;
        t_block t;
        s = blk;
        if (op == OP_ENCRYPT) begin
            for (int r = 0; r < ROUNDS_WITH_PERM; r++) begin
                t = substitute(s ^ key, 1'b0);
                for (int i = 0; i < 16; i++) begin
                    s[PERM_DEST[4*i +: 4]] = t[i];
                end
            end
            s = substitute(s ^ key, 1'b0);
        end else begin
            s = substitute(s, 1'b1) ^ key;
            for (int r = 0; r < ROUNDS_WITH_PERM; r++) begin
                for (int i = 0; i < 16; i++) begin
                    t[i] = s[PERM_DEST[4*i +: 4]];
                end
                s = substitute(t, 1'b1) ^ key;
            end
        end
        return s;
    endfunction

    task automatic note_mismatch(input string what, input t_block exp_val,
                                 input t_block act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("MISMATCH %s: expected %h, got %h at cycle %0d",
                     what, exp_val, act_val, cycle_count);
        end
    endtask

    always @(posedge i_clk) begin
        t_block exp_val;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                note_mismatch("unexpected item", 16'h0000, o_block_out);
            end else begin
                exp_val = expected_blocks.pop_front();
                if (o_block_out !== exp_val) begin
                    note_mismatch("block_out", exp_val, o_block_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("tb_spn16_block_cipher_core: done, errors");
            $finish;
        end
    end

    // A pending hold-off takes priority over random stalling.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Entered and left at a falling edge; valid stays high after the item.
    task automatic send_block(input t_cipher_op op, input t_block blk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func = op;
        i_block_in = blk;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_blocks.push_back(predict_block(op, blk, cur_key));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (expected_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_key(input t_block key);
        wait_idle();
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = key;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        cur_key = key;
    endtask

    task automatic test_reset_key();
        send_idle_pct = 0;
        stall_pct = 0;
        send_block(OP_ENCRYPT, 16'h0000);
        send_block(OP_DECRYPT, 16'h0000);
        send_block(OP_ENCRYPT, 16'hFFFF);
        send_block(OP_DECRYPT, 16'hFFFF);
    endtask

    task automatic test_directed_keys();
        write_key(16'hFFFF);
        send_block(OP_ENCRYPT, 16'h0000);
        send_block(OP_DECRYPT, 16'h0000);
        send_block(OP_ENCRYPT, 16'hFFFF);
        send_block(OP_DECRYPT, 16'hFFFF);
        send_block(OP_ENCRYPT, 16'h5555);
        send_block(OP_DECRYPT, 16'h5555);
        send_block(OP_ENCRYPT, 16'hAAAA);
        send_block(OP_DECRYPT, 16'hAAAA);
        write_key(16'h3C5A);
        send_block(OP_ENCRYPT, 16'h0001);
        send_block(OP_ENCRYPT, 16'h8000);
        send_block(OP_DECRYPT, 16'h0001);
        send_block(OP_DECRYPT, 16'h8000);
    endtask

    task automatic test_random_phase(input t_block key, input int idle_pct,
                                     input int stall_chance);
        write_key(key);
        send_idle_pct = idle_pct;
        stall_pct = stall_chance;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_block(t_cipher_op'($urandom_range(1)), t_block'($urandom_range(16'hFFFF)));
        end
    endtask

    task automatic test_backpressure();
        write_key(t_block'($urandom_range(16'hFFFF)));
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        for (int n = 0; n < 40; n++) begin
            send_block(t_cipher_op'($urandom_range(1)), t_block'($urandom_range(16'hFFFF)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 16'h0000;
        i_in_valid = 1'b0;
        i_func = OP_ENCRYPT;
        i_block_in = 16'h0000;
        i_out_stall = 1'b0;
        cur_key = 16'h0000;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_directed_keys();
        test_random_phase(t_block'($urandom_range(16'hFFFF)), 0, 0);
        test_random_phase(16'h0000, 84, 0);
        test_random_phase(t_block'($urandom_range(16'hFFFF)), 0, 84);
        test_random_phase(16'hFFFF, 15, 15);
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_spn16_block_cipher_core: done, clean");
        end else begin
            $display("tb_spn16_block_cipher_core: done, errors");
        end
        $finish;
    end

endmodule
